### design/drc_pkg.sv
package drc_pkg;

  // Field widths
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 6;
  localparam int ADDR_W     = 32;
  localparam int STRIDE_W   = 16;
  localparam int UF_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int PACKETS_MAX_DEFAULT = 64;

  // Operation codes
  localparam logic [1:0] OP_INTERRUPT    = 2'd0;
  localparam logic [1:0] OP_CHECK        = 2'd1;
  localparam logic [1:0] OP_QUEUE        = 2'd2;
  localparam logic [1:0] OP_RESTART_DONE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PACKETS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_PRESET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CB_BASE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CB_STRIDE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_STRIDE  = 3'd5;

  // Configuration reset values
  localparam logic [CNT_W-1:0]    NUM_PACKETS_RST  = 7'd8;
  localparam logic [CNT_W-1:0]    PRIME_PRESET_RST = 7'd2;
  localparam logic [STRIDE_W-1:0] STRIDE_RST       = 16'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic              int_flag;
    logic              error_flag;
    logic              active_flag;
    logic [ADDR_W-1:0] conblk_addr;
    logic [ADDR_W-1:0] source_addr;
    logic [CNT_W-1:0]  add_count;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic              restart_request;
    logic [CNT_W-1:0]  prime_count;
    logic [IDX_W-1:0]  completed_index;
    logic [CNT_W-1:0]  processed_count;
    logic              underflow;
    logic [CNT_W-1:0]  in_use_count;
    logic [ADDR_W-1:0] processed_total;
    logic              notify;
  } result_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
  } link_t;

endpackage

### design/drc_scan_cell.sv
module drc_scan_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [drc_pkg::ADDR_W-1:0]    key,
  input  logic [drc_pkg::STRIDE_W-1:0]  stride,
  input  logic [drc_pkg::CNT_W-1:0]     ring_n,
  input  drc_pkg::link_t                link_in,
  output drc_pkg::link_t                link_out
);

  logic hit;

  // Match the first packet in the ring whose address is not below the key
  assign hit = link_in.valid && !link_in.found &&
               (drc_pkg::CNT_W'(IDX) < ring_n) && (key <= link_in.addr);

  // Advance the token valid bit, the address and the match result
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.valid <= 1'b0;
    end else begin
      link_out.valid <= link_in.valid;
    end
    link_out.found <= link_in.found | hit;
    link_out.idx   <= hit ? drc_pkg::IDX_W'(IDX) : link_in.idx;
    link_out.addr  <= link_in.addr + {{(drc_pkg::ADDR_W-drc_pkg::STRIDE_W){1'b0}}, stride};
  end

endmodule

### design/dma_ring_completion_tracker.sv
// DMA ring completion tracker.
// Requests arrive on item and are taken at a rising edge with start high
// and busy low. Each request yields exactly one result, shown on result for
// a single cycle with done high; the receiver cannot stall it, so it must
// take every result in that cycle.
// Configuration goes through cfg_write/cfg_index/cfg_data, one register per
// edge; write only while busy is low, which the block does not enforce.
// A request that needs an address scan (interrupt from a running
// or underflowed channel, deferred check on an underflow) passes through
// LAUNCH, SCAN and APPLY; any other request goes from LAUNCH to APPLY.
// busy drops in the cycle done rises, so the next request can be taken at
// the edge ending that cycle.
// The scan runs through a chain of PACKETS_MAX cells, one packet address
// compared per cell per cycle; the chain length sets the scan latency.
// Reset (synchronous, active high) clears all tracking state, restores the
// configuration defaults and leaves the block idle and ready.
module dma_ring_completion_tracker #(
  parameter int PACKETS_MAX = drc_pkg::PACKETS_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  drc_pkg::item_t                  item,
  output logic                            done,
  output drc_pkg::result_t                result,
  input  logic                            cfg_write,
  input  logic [drc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW = drc_pkg::CNT_W;
  localparam int IW = drc_pkg::IDX_W;
  localparam int AW = drc_pkg::ADDR_W;
  localparam int SW = drc_pkg::STRIDE_W;
  localparam int UW = drc_pkg::UF_W;

  // Configuration
  logic [CW-1:0] num_packets, prime_preset;
  logic [AW-1:0] cb_base, data_base;
  logic [SW-1:0] cb_stride, data_stride;

  // Tracking state
  logic [IW-1:0] last_completed, last_completed_next;
  logic          last_valid, last_valid_next;
  logic [CW-1:0] in_use, in_use_next;
  logic [CW-1:0] to_prime, to_prime_next;
  logic          restart_pending, restart_pending_next;
  logic [AW-1:0] total_processed, total_processed_next;
  logic [UW-1:0] underflow_events, underflow_events_next;

  drc_pkg::state_t  state, state_next;
  drc_pkg::item_t   req;
  drc_pkg::result_t res_next;

  logic          accept;
  logic          need_scan, use_data, launch;
  logic [CW-1:0] ring_n, pre;
  logic [AW-1:0] scan_key, scan_base;
  logic [SW-1:0] scan_stride;
  logic          scan_found;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] done_idx;
  logic [CW-1:0] cnt;
  logic [CW:0]   cnt_wide;
  logic          do_uf;

  drc_pkg::link_t links [PACKETS_MAX+1];

  assign accept = start && !busy;
  assign busy   = (state != drc_pkg::ST_IDLE);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_packets  <= drc_pkg::NUM_PACKETS_RST;
      prime_preset <= drc_pkg::PRIME_PRESET_RST;
      cb_base      <= '0;
      cb_stride    <= drc_pkg::STRIDE_RST;
      data_base    <= '0;
      data_stride  <= drc_pkg::STRIDE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        drc_pkg::REG_NUM_PACKETS:  num_packets  <= cfg_data[CW-1:0];
        drc_pkg::REG_PRIME_PRESET: prime_preset <= cfg_data[CW-1:0];
        drc_pkg::REG_CB_BASE:      cb_base      <= cfg_data[AW-1:0];
        drc_pkg::REG_CB_STRIDE:    cb_stride    <= cfg_data[SW-1:0];
        drc_pkg::REG_DATA_BASE:    data_base    <= cfg_data[AW-1:0];
        drc_pkg::REG_DATA_STRIDE:  data_stride  <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp ring size and priming preset
  assign ring_n = (num_packets == '0) ? CW'(1) :
                  (num_packets > CW'(PACKETS_MAX)) ? CW'(PACKETS_MAX) : num_packets;
  assign pre    = (prime_preset > CW'(PACKETS_MAX)) ? CW'(PACKETS_MAX) : prime_preset;

  // Hold the request while it is worked on
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= item;
    end
  end

  // Decide which scan, if any, the held request needs
  always_comb begin
    need_scan = 1'b0;
    use_data  = 1'b0;
    if (req.operation == drc_pkg::OP_INTERRUPT && req.int_flag && !req.error_flag) begin
      if (req.active_flag) begin
        need_scan = 1'b1;
      end else if (req.conblk_addr == '0) begin
        need_scan = 1'b1;
        use_data  = 1'b1;
      end
    end else if (req.operation == drc_pkg::OP_CHECK && !req.active_flag &&
                 !restart_pending && req.conblk_addr == '0) begin
      need_scan = 1'b1;
      use_data  = 1'b1;
    end
  end

  assign scan_key    = use_data ? req.source_addr : req.conblk_addr;
  assign scan_base   = use_data ? data_base : cb_base;
  assign scan_stride = use_data ? data_stride : cb_stride;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      drc_pkg::ST_IDLE:   if (accept) state_next = drc_pkg::ST_LAUNCH;
      drc_pkg::ST_LAUNCH: state_next = need_scan ? drc_pkg::ST_SCAN : drc_pkg::ST_APPLY;
      drc_pkg::ST_SCAN:   if (links[PACKETS_MAX].valid) state_next = drc_pkg::ST_APPLY;
      drc_pkg::ST_APPLY:  state_next = drc_pkg::ST_IDLE;
      default:            state_next = drc_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    launch = 1'b0;
    unique case (state)
      drc_pkg::ST_LAUNCH: launch = need_scan;
      default:            launch = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= drc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Feed the head of the chain
  assign links[0] = '{valid: launch, found: 1'b0, idx: {IW{1'b0}}, addr: scan_base};

  for (genvar k = 0; k < PACKETS_MAX; k++) begin : g_cell
    drc_scan_cell #(
      .IDX(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .key     (scan_key),
      .stride  (scan_stride),
      .ring_n  (ring_n),
      .link_in (links[k]),
      .link_out(links[k+1])
    );
  end

  // Hold the match as the token leaves the end of the chain
  always_ff @(posedge clk) begin
    if (links[PACKETS_MAX].valid) begin
      scan_found <= links[PACKETS_MAX].found;
      scan_idx   <= links[PACKETS_MAX].idx;
    end
  end

  // Completed packet is the one before the match, wrapping to the ring end
  assign done_idx = (scan_found && scan_idx != '0) ?
                    scan_idx - IW'(1) : IW'(ring_n - CW'(1));

  // Packets finished since the last known completion
  always_comb begin
    if (!last_valid || {1'b0, last_completed} >= ring_n) begin
      cnt_wide = {2'b00, done_idx} + (CW+1)'(1);
    end else if (done_idx > last_completed) begin
      cnt_wide = {2'b00, done_idx} - {2'b00, last_completed};
    end else begin
      cnt_wide = {2'b00, done_idx} + {1'b0, ring_n} - {2'b00, last_completed};
    end
  end
  assign cnt = cnt_wide[CW-1:0];

  // Apply the request to the tracking state and build the result
  always_comb begin
    logic [CW:0] sum;
    last_completed_next   = last_completed;
    last_valid_next       = last_valid;
    in_use_next           = in_use;
    to_prime_next         = to_prime;
    restart_pending_next  = restart_pending;
    total_processed_next  = total_processed;
    underflow_events_next = underflow_events;
    res_next              = '0;
    do_uf                 = 1'b0;
    sum                   = '0;
    unique case (req.operation)
      drc_pkg::OP_INTERRUPT: begin
        if (req.int_flag) begin
          res_next.accepted = 1'b1;
          if (req.error_flag) begin
            restart_pending_next = 1'b1;
          end else if (!req.active_flag) begin
            do_uf = (req.conblk_addr == '0);
          end else begin
            if (({1'b0, in_use} + {1'b0, pre}) < {1'b0, ring_n} && to_prime < pre) begin
              to_prime_next = pre;
            end
            last_completed_next      = done_idx;
            last_valid_next          = 1'b1;
            in_use_next              = (in_use > cnt) ? in_use - cnt : '0;
            total_processed_next     = total_processed + {{(AW-CW){1'b0}}, cnt};
            res_next.completed_index = done_idx;
            res_next.processed_count = cnt;
          end
        end
      end
      drc_pkg::OP_CHECK: begin
        do_uf = !req.active_flag && !restart_pending && (req.conblk_addr == '0);
        res_next.notify = 1'b1;
      end
      drc_pkg::OP_QUEUE: begin
        sum           = {1'b0, in_use} + {1'b0, req.add_count};
        in_use_next   = (sum > {1'b0, ring_n}) ? ring_n : sum[CW-1:0];
        to_prime_next = (to_prime > req.add_count) ? to_prime - req.add_count : '0;
      end
      drc_pkg::OP_RESTART_DONE: begin
        restart_pending_next = 1'b0;
      end
      default: ;
    endcase
    // Underflow: drop in-use, count the scan result, request a restart
    if (do_uf) begin
      in_use_next              = '0;
      total_processed_next     = total_processed + {{(AW-CW){1'b0}}, cnt};
      underflow_events_next    = underflow_events + UW'(1);
      restart_pending_next     = 1'b1;
      res_next.completed_index = done_idx;
      res_next.processed_count = cnt;
      res_next.underflow       = 1'b1;
    end
    res_next.restart_request = restart_pending_next;
    res_next.prime_count     = to_prime_next;
    res_next.in_use_count    = in_use_next;
    res_next.processed_total = total_processed_next;
  end

  // Commit tracking state at the end of each request
  always_ff @(posedge clk) begin
    if (rst) begin
      last_completed   <= '0;
      last_valid       <= 1'b0;
      in_use           <= '0;
      to_prime         <= '0;
      restart_pending  <= 1'b0;
      total_processed  <= '0;
      underflow_events <= '0;
    end else if (state == drc_pkg::ST_APPLY) begin
      last_completed   <= last_completed_next;
      last_valid       <= last_valid_next;
      in_use           <= in_use_next;
      to_prime         <= to_prime_next;
      restart_pending  <= restart_pending_next;
      total_processed  <= total_processed_next;
      underflow_events <= underflow_events_next;
    end
  end

  // Present the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == drc_pkg::ST_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == drc_pkg::ST_APPLY) begin
      result <= res_next;
    end
  end

  a_apply_done: assert property (@(posedge clk) disable iff (rst)
    (state == drc_pkg::ST_APPLY) |=> done)
    else $error("result strobe missing after apply");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_chain_scan: assert property (@(posedge clk) disable iff (rst)
    links[PACKETS_MAX].valid |-> (state == drc_pkg::ST_SCAN))
    else $error("scan token left the chain outside a scan");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not raise busy");

  a_in_use_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= CW'(PACKETS_MAX))
    else $error("in-use count above ring capacity");

endmodule
